// ----- rtl/wavetable_oscillator_interp_assert.svh -----
// assertion macros shared by the oscillator modules
// each expects clk and rst_n in scope
`ifndef WAVETABLE_OSCILLATOR_INTERP_ASSERT_SVH
`define WAVETABLE_OSCILLATOR_INTERP_ASSERT_SVH
`ifndef SYNTHESIS
// consequent must hold in the same cycle
`define WTO_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// consequent must hold in the next cycle
`define WTO_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define WTO_ASSERT_SAME(label, ante, cons, msg)
`define WTO_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

// ----- rtl/wto_pkg.sv -----
package wto_pkg;

  // default parameter values
  localparam int TABLE_DEPTH_DEF  = 4096;
  localparam int FRAC_BITS_DEF    = 16;
  localparam int SAMPLE_WIDTH_DEF = 16;

  // fixed field widths
  localparam int TABLE_LENGTH_W = 13;
  localparam int SCALE_W        = 24;
  localparam int FREQ_W         = 25;
  localparam int TABLE_ADDR_W   = 12;
  localparam int CFG_IDX_W      = 1;
  localparam int CFG_DATA_W     = 24;

  // fraction bits of frequency (Q17.8) times scale (Q0.24)
  localparam int PROD_FRAC = 32;

  localparam logic [TABLE_LENGTH_W-1:0] TABLE_LENGTH_RESET = 13'd4096;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_TABLE_LENGTH    = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INCREMENT_SCALE = 1'd1;

  // item commands
  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_GEN  = 1'b1;

  // controller to datapath
  typedef struct packed {
    logic accept;
    logic mod_start;
    logic mod_take;
    logic load_write;
    logic mul_lo;
    logic mul_hi;
    logic sat;
    logic phase_step;
    logic rd;
    logic diff;
    logic finish;
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic load_wrap;
    logic phase_wrap;
    logic mod_done;
    logic out_free;
  } ctrl_status_t;

endpackage

// ----- rtl/wto_mod.sv -----
`include "wavetable_oscillator_interp_assert.svh"

module wto_mod #(
  parameter int DIV_W = 12,
  parameter int LEN_W = 13
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DIV_W-1:0] dividend,
  input  logic [LEN_W-1:0] divisor,
  output logic             done,
  output logic [DIV_W-1:0] rem
);

  localparam int SH_W  = DIV_W + LEN_W;
  localparam int CNT_W = $clog2(DIV_W);

  logic             busy_r;
  logic             done_r;
  logic [CNT_W-1:0] cnt_r;
  logic [DIV_W-1:0] rem_r;
  logic [SH_W-1:0]  shifted;
  logic [DIV_W-1:0] rem_nxt;

  // one restoring step per cycle, top bit first
  always_comb begin
    shifted = SH_W'(divisor) << cnt_r;
    if (SH_W'(rem_r) >= shifted) begin
      rem_nxt = DIV_W'(SH_W'(rem_r) - shifted);
    end else begin
      rem_nxt = rem_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        rem_r  <= dividend;
        cnt_r  <= CNT_W'(DIV_W - 1);
      end else if (busy_r) begin
        rem_r <= rem_nxt;
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          cnt_r <= cnt_r - 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign rem  = rem_r;

  `WTO_ASSERT_SAME(a_rem_below_divisor, done_r, SH_W'(rem_r) < SH_W'(divisor), "remainder not reduced")
  `WTO_ASSERT_SAME(a_start_when_free, start, !busy_r, "reduction restarted while busy")

endmodule

// ----- rtl/wto_ctrl.sv -----
`include "wavetable_oscillator_interp_assert.svh"

module wto_ctrl import wto_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_valid,
  input  logic         in_cmd,
  output logic         in_stall,
  input  ctrl_status_t status,
  output ctrl_cmd_t    cmd
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_LOAD,
    S_MOD_LD,
    S_WRITE,
    S_MUL_LO,
    S_MOD_GEN,
    S_MUL_HI,
    S_SAT,
    S_PHASE,
    S_READ,
    S_DIFF,
    S_INTERP
  } state_t;

  state_t state_r;
  state_t state_nxt;

  // sequencing and command decode
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = (in_cmd == CMD_GEN) ? S_MUL_LO : S_LOAD;
        end
      end
      S_LOAD: begin
        if (status.load_wrap) begin
          cmd.mod_start = 1'b1;
          state_nxt     = S_MOD_LD;
        end else begin
          cmd.load_write = 1'b1;
          state_nxt      = S_IDLE;
        end
      end
      S_MOD_LD: begin
        if (status.mod_done) begin
          cmd.mod_take = 1'b1;
          state_nxt    = S_WRITE;
        end
      end
      S_WRITE: begin
        cmd.load_write = 1'b1;
        state_nxt      = S_IDLE;
      end
      S_MUL_LO: begin
        cmd.mul_lo = 1'b1;
        if (status.phase_wrap) begin
          cmd.mod_start = 1'b1;
          state_nxt     = S_MOD_GEN;
        end else begin
          state_nxt = S_MUL_HI;
        end
      end
      S_MOD_GEN: begin
        if (status.mod_done) begin
          cmd.mod_take = 1'b1;
          state_nxt    = S_MUL_HI;
        end
      end
      S_MUL_HI: begin
        cmd.mul_hi = 1'b1;
        state_nxt  = S_SAT;
      end
      S_SAT: begin
        cmd.sat   = 1'b1;
        state_nxt = S_PHASE;
      end
      S_PHASE: begin
        cmd.phase_step = 1'b1;
        state_nxt      = S_READ;
      end
      S_READ: begin
        cmd.rd    = 1'b1;
        state_nxt = S_DIFF;
      end
      S_DIFF: begin
        cmd.diff  = 1'b1;
        state_nxt = S_INTERP;
      end
      S_INTERP: begin
        if (status.out_free) begin
          cmd.finish = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_stall = (state_r != S_IDLE);

  `WTO_ASSERT_NEXT(a_busy_after_accept, cmd.accept, in_stall, "accepted beat not held off")

endmodule

// ----- rtl/wto_dp.sv -----
`include "wavetable_oscillator_interp_assert.svh"

module wto_dp import wto_pkg::*; #(
  parameter int TABLE_DEPTH  = TABLE_DEPTH_DEF,
  parameter int FRAC_BITS    = FRAC_BITS_DEF,
  parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  ctrl_cmd_t                      cmd,
  output ctrl_status_t                   status,
  input  logic                           cfg_we,
  input  logic [CFG_IDX_W-1:0]           cfg_index,
  input  logic [CFG_DATA_W-1:0]          cfg_wdata,
  input  logic                           in_cmd,
  input  logic [TABLE_ADDR_W-1:0]        in_table_address,
  input  logic signed [SAMPLE_WIDTH-1:0] in_table_value,
  input  logic signed [SAMPLE_WIDTH-1:0] in_amplitude,
  input  logic [FREQ_W-1:0]              in_frequency,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic signed [SAMPLE_WIDTH-1:0] out_sample
);

  localparam int SW     = SAMPLE_WIDTH;
  localparam int ADDR_W = $clog2(TABLE_DEPTH);
  localparam int LEN_W  = $clog2(TABLE_DEPTH + 1);
  localparam int PH_W   = ADDR_W + FRAC_BITS;
  localparam int DIV_W  = (ADDR_W > TABLE_ADDR_W) ? ADDR_W : TABLE_ADDR_W;
  localparam int SC_LO_W = SCALE_W / 2;
  localparam int SC_HI_W = SCALE_W - SC_LO_W;
  localparam int MP_W   = FREQ_W + SC_HI_W;
  localparam int PROD_W = FREQ_W + SCALE_W;
  localparam int SHR    = PROD_FRAC - FRAC_BITS;
  localparam int IW     = PROD_W - SHR;
  localparam int LF_W   = LEN_W + FRAC_BITS;
  localparam int CMP_W  = (IW > PH_W + 1) ? IW : PH_W + 1;
  localparam int SPW    = 2 * SW;
  localparam int DW     = SW + 1;
  localparam int DPW    = DW + FRAC_BITS + 1;

  localparam logic signed [SPW-1:0] SMAX = SPW'((64'sd1 <<< (SW - 1)) - 64'sd1);
  localparam logic signed [SPW-1:0] SMIN = -SMAX - SPW'(1);

  // configuration
  logic [TABLE_LENGTH_W-1:0] tl_r;
  logic [SCALE_W-1:0]        scale_r;

  // latched item
  logic                    cmd_r;
  logic [TABLE_ADDR_W-1:0] addr_r;
  logic signed [SW-1:0]    value_r;
  logic signed [SW-1:0]    amp_r;
  logic [FREQ_W-1:0]       freq_r;

  // oscillator state and pipeline registers
  logic [PH_W-1:0]        phase_r;
  logic signed [SW-1:0]   held_r;
  logic signed [SPW-1:0]  prod_r;
  logic [MP_W-1:0]        p_lo_r;
  logic [PROD_W-1:0]      acc_r;
  logic [PH_W-1:0]        inc_r;
  logic signed [SW-1:0]   a_r;
  logic signed [SW-1:0]   b_r;
  logic signed [DPW-1:0]  dprod_r;
  logic                   out_valid_r;
  logic signed [SW-1:0]   out_sample_r;

  logic signed [SW-1:0] mem [TABLE_DEPTH];

  logic [LEN_W-1:0]    len_c;
  logic [LF_W-1:0]     lfix_c;
  logic [ADDR_W-1:0]   idx_c;
  logic [ADDR_W-1:0]   nxt_c;
  logic [ADDR_W:0]     idx_p1;
  logic [SC_HI_W-1:0]  sc_op;
  logic [MP_W-1:0]     mul_p;
  logic [CMP_W-1:0]    inc_full;
  logic [CMP_W-1:0]    lfix_m1;
  logic [PH_W:0]       ph_sum;
  logic [PH_W:0]       lfix_p;
  logic [PH_W:0]       ph_new;
  logic signed [DW-1:0]  diff_c;
  logic signed [SPW-1:0] prod_sh;
  logic signed [SW-1:0]  sample_c;
  logic [DIV_W-1:0]    mod_dividend;
  logic [LEN_W-1:0]    mod_divisor;
  logic                mod_done;
  logic [DIV_W-1:0]    mod_rem;

  // active length, clamped into the usable range
  always_comb begin
    if (tl_r < TABLE_LENGTH_W'(2)) begin
      len_c = LEN_W'(2);
    end else if (32'(tl_r) > 32'(TABLE_DEPTH)) begin
      len_c = LEN_W'(TABLE_DEPTH);
    end else begin
      len_c = LEN_W'(tl_r);
    end
    lfix_c = {len_c, {FRAC_BITS{1'b0}}};
  end

  // table indexes, next entry wraps at the active length
  always_comb begin
    idx_c  = phase_r[PH_W-1:FRAC_BITS];
    idx_p1 = (ADDR_W + 1)'(idx_c) + 1'b1;
    if (idx_p1 >= (ADDR_W + 1)'(len_c)) begin
      nxt_c = '0;
    end else begin
      nxt_c = ADDR_W'(idx_p1);
    end
  end

  // shared frequency times scale multiplier, low half then high half
  assign sc_op = cmd.mul_hi ? scale_r[SCALE_W-1:SC_LO_W] : SC_HI_W'(scale_r[SC_LO_W-1:0]);
  assign mul_p = MP_W'(freq_r) * MP_W'(sc_op);

  // increment saturation below one table length
  always_comb begin
    inc_full = CMP_W'(acc_r[PROD_W-1:SHR]);
    lfix_m1  = CMP_W'(lfix_c) - 1'b1;
  end

  // phase advance with wrap
  always_comb begin
    ph_sum = (PH_W + 1)'(phase_r) + (PH_W + 1)'(inc_r);
    lfix_p = (PH_W + 1)'(lfix_c);
    if (ph_sum >= lfix_p) begin
      ph_new = ph_sum - lfix_p;
    end else begin
      ph_new = ph_sum;
    end
  end

  // output scaling, floor then saturate
  always_comb begin
    diff_c  = DW'(b_r) - DW'(a_r);
    prod_sh = prod_r >>> (SW - 1);
    if (prod_sh > SMAX) begin
      sample_c = SW'(SMAX);
    end else if (prod_sh < SMIN) begin
      sample_c = SW'(SMIN);
    end else begin
      sample_c = SW'(prod_sh);
    end
  end

  // range reduction of write address or phase index
  assign mod_dividend = (cmd_r == CMD_GEN) ? DIV_W'(idx_c) : DIV_W'(addr_r);
  assign mod_divisor  = (cmd_r == CMD_GEN) ? len_c : LEN_W'(TABLE_DEPTH);

  wto_mod #(
    .DIV_W (DIV_W),
    .LEN_W (LEN_W)
  ) u_mod (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.mod_start),
    .dividend (mod_dividend),
    .divisor  (mod_divisor),
    .done     (mod_done),
    .rem      (mod_rem)
  );

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tl_r    <= TABLE_LENGTH_RESET;
      scale_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_TABLE_LENGTH:    tl_r    <= cfg_wdata[TABLE_LENGTH_W-1:0];
        REG_INCREMENT_SCALE: scale_r <= cfg_wdata[SCALE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // item capture and arithmetic pipeline
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      cmd_r   <= in_cmd;
      addr_r  <= in_table_address;
      value_r <= in_table_value;
      amp_r   <= in_amplitude;
      freq_r  <= in_frequency;
    end
    if (cmd.mod_take && cmd_r == CMD_LOAD) begin
      addr_r <= TABLE_ADDR_W'(mod_rem);
    end
    if (cmd.mul_lo) begin
      p_lo_r <= mul_p;
      prod_r <= SPW'(amp_r) * SPW'(held_r);
    end
    if (cmd.mul_hi) begin
      acc_r <= PROD_W'(p_lo_r) + (PROD_W'(mul_p) << SC_LO_W);
    end
    if (cmd.sat) begin
      inc_r <= (inc_full > lfix_m1) ? PH_W'(lfix_m1) : PH_W'(inc_full);
    end
    if (cmd.diff) begin
      dprod_r <= DPW'(diff_c) * DPW'($signed({1'b0, phase_r[FRAC_BITS-1:0]}));
    end
    if (cmd.finish) begin
      out_sample_r <= sample_c;
    end
  end

  // wave table, one write port and two registered read ports
  always_ff @(posedge clk) begin
    if (cmd.load_write) begin
      mem[ADDR_W'(addr_r)] <= value_r;
    end
    if (cmd.rd) begin
      a_r <= mem[idx_c];
      b_r <= mem[nxt_c];
    end
  end

  // oscillator state and output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= '0;
      held_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.mod_take && cmd_r == CMD_GEN) begin
        phase_r[PH_W-1:FRAC_BITS] <= ADDR_W'(mod_rem);
      end else if (cmd.phase_step) begin
        phase_r <= PH_W'(ph_new);
      end
      if (cmd.finish) begin
        held_r      <= SW'(DPW'(a_r) + (dprod_r >>> FRAC_BITS));
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_comb begin
    status.load_wrap  = 32'(addr_r) >= 32'(TABLE_DEPTH);
    status.phase_wrap = 32'(idx_c) >= 32'(len_c);
    status.mod_done   = mod_done;
    status.out_free   = !out_valid_r || !out_stall;
  end

  assign out_valid  = out_valid_r;
  assign out_sample = out_sample_r;

  `WTO_ASSERT_NEXT(a_phase_in_range, cmd.phase_step, (PH_W + 1)'(phase_r) < lfix_p, "phase past table length")
  `WTO_ASSERT_NEXT(a_result_posted, cmd.finish, out_valid_r, "result beat lost")

endmodule

// ----- rtl/wavetable_oscillator_interp.sv -----
// generate beat: multiply, saturate, phase step, table read, difference, registered result
// load beat: table write; each beat is done before the next is accepted; the remainder unit,
// a bit per cycle, lengthens loads past the table depth and generates past the active length
// a waiting result stalls completion of the following generate beat in its last step
// rst_n synchronous active low: clears phase, held value, sequencer, output valid,
// table_length to 4096 and increment_scale to 0; table contents stay undefined until written
module wavetable_oscillator_interp import wto_pkg::*; #(
  parameter int TABLE_DEPTH  = TABLE_DEPTH_DEF,
  parameter int FRAC_BITS    = FRAC_BITS_DEF,
  parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [CFG_IDX_W-1:0]           cfg_index,
  input  logic [CFG_DATA_W-1:0]          cfg_wdata,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           in_cmd,
  input  logic [TABLE_ADDR_W-1:0]        in_table_address,
  input  logic signed [SAMPLE_WIDTH-1:0] in_table_value,
  input  logic signed [SAMPLE_WIDTH-1:0] in_amplitude,
  input  logic [FREQ_W-1:0]              in_frequency,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic signed [SAMPLE_WIDTH-1:0] out_sample
);

  ctrl_cmd_t    cmd;
  ctrl_status_t status;

  // sequencer
  wto_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_cmd   (in_cmd),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  // table, phase and arithmetic
  wto_dp #(
    .TABLE_DEPTH  (TABLE_DEPTH),
    .FRAC_BITS    (FRAC_BITS),
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .status           (status),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_cmd           (in_cmd),
    .in_table_address (in_table_address),
    .in_table_value   (in_table_value),
    .in_amplitude     (in_amplitude),
    .in_frequency     (in_frequency),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_sample       (out_sample)
  );

endmodule
